// ----- rtl/gmla_pkg.sv -----
// Types and constants for the gray mask level adjust pipeline.
// No dependencies.
`default_nettype none

package gmla_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_POINT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 3'd3;

  localparam int Q_ONE = 16384;
  localparam logic [7:0] MID_DEFAULT = 8'd127;
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic signed [24:0] MID_Y_BASE = 25'sd2080768;  // 127 * Q_ONE
  localparam logic signed [24:0] FULL_Y = 25'sd4177920;      // 255 * Q_ONE

  localparam int QBITS = 8;
  localparam int DIV_W = 50;
  localparam int NSTG = 7 + QBITS;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_LEVEL,
    MODE_CURVE
  } mode_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] level;
    pix_t       px;
  } ctl_t;

  typedef struct packed {
    ctl_t               ctl;
    logic signed [9:0]  diff_s;
    logic [7:0]         w;
    logic [15:0]        ad;
    logic               wzero;
    logic signed [24:0] my;
    logic signed [24:0] y;
  } s2_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [23:0]        p1;
    logic signed [34:0] yg;
    logic signed [24:0] my;
    logic               wzero;
  } s3_t;

  typedef struct packed {
    ctl_t               ctl;
    logic signed [49:0] t1;
    logic signed [48:0] qyg;
    logic [37:0]        dd;
  } s4_t;

  typedef struct packed {
    ctl_t             ctl;
    logic             neg;
    logic [DIV_W-1:0] x;
    logic [38:0]      d2;
  } s5_t;

  typedef struct packed {
    ctl_t             ctl;
    logic             neg;
    logic             over;
    logic [DIV_W-1:0] rem;
    logic [38:0]      d2;
    logic [QBITS-1:0] q;
  } div_t;

endpackage

`default_nettype wire

// ----- rtl/gray_mask_level_adjust.sv -----
// Gray mask level adjust: pixel pipeline with curve evaluation and bit-per-stage divider.
// Depends on gmla_pkg.
//
// Usage:
//   Pixel requests enter on in_valid_i/in_ready_o with red/green/blue/alpha bytes and
//   leave on out_valid_o/out_ready_i, one result per request, in order.
//   Settings are written through cfg_we_i/cfg_idx_i/cfg_data_i (0 mask enable,
//   1 mid point, 2 brightness, 3 contrast, Q2.14); other indexes are ignored.
//   Write them only while the pipeline is empty.
// Depth: 15 register stages, from the input register through to the output register.
// Throughput: one pixel per cycle unless stalled; the restoring divider sets depth and
//   resolves one quotient bit per stage, preceded by the luma, multiply and sum stages.
// Reset: pipeline empties, mask off, mid point 127, brightness and contrast zero.
// Stall: each stage holds while the one after it is full and held, so empty stages
//   still fill and in_ready_o only falls once every stage holds a pixel.
`default_nettype none

module gray_mask_level_adjust (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [gmla_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [gmla_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire [7:0]                       red_in_i,
  input  wire [7:0]                       green_in_i,
  input  wire [7:0]                       blue_in_i,
  input  wire [7:0]                       alpha_in_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [7:0]                      red_out_o,
  output logic [7:0]                      green_out_o,
  output logic [7:0]                      blue_out_o,
  output logic [7:0]                      alpha_out_o
);

  localparam int NS = gmla_pkg::NSTG;
  localparam int QB = gmla_pkg::QBITS;
  localparam int DV0 = 5;

  // settings
  logic               cfg_en_q;
  logic [7:0]         cfg_mid_q;
  logic signed [15:0] cfg_bri_q;
  logic signed [15:0] cfg_con_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_en_q  <= 1'b0;
      cfg_mid_q <= gmla_pkg::MID_DEFAULT;
      cfg_bri_q <= '0;
      cfg_con_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gmla_pkg::REG_MASK_EN:    cfg_en_q  <= cfg_data_i[0];
        gmla_pkg::REG_MID_POINT:  cfg_mid_q <= cfg_data_i[7:0];
        gmla_pkg::REG_BRIGHTNESS: cfg_bri_q <= $signed(cfg_data_i);
        gmla_pkg::REG_CONTRAST:   cfg_con_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // stage control
  logic [NS-1:0] en;
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_d        = {v_q[NS-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  // stage 0: input register
  gmla_pkg::pix_t in_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_q <= '{r: red_in_i, g: green_in_i, b: blue_in_i, a: alpha_in_i};
    end
  end

  // stage 1: luma, mode, segment select, midY
  gmla_pkg::s2_t      s2_d, s2_q;
  logic [12:0]        lum_sum;
  logic [7:0]         gray;
  logic               adj;
  logic signed [17:0] con_d;
  logic signed [17:0] con_n;
  logic signed [24:0] bri_x;
  logic signed [24:0] my;
  logic signed [9:0]  diff;
  logic               lower;

  always_comb begin
    lum_sum = ({5'b0, in_q.r} * 13'd11) + ({5'b0, in_q.g} << 4) + ({5'b0, in_q.b} * 13'd5);
    gray    = lum_sum[12:5];
    adj     = (cfg_mid_q != gmla_pkg::MID_DEFAULT) || (cfg_bri_q != '0) || (cfg_con_q != '0);
    con_d   = 18'(gmla_pkg::Q_ONE) - {{2{cfg_con_q[15]}}, cfg_con_q};
    con_n   = -con_d;
    bri_x   = {{9{cfg_bri_q[15]}}, cfg_bri_q};
    if (cfg_bri_q > 16'sd0) begin
      my = gmla_pkg::MID_Y_BASE + (bri_x <<< 7);
    end else begin
      my = gmla_pkg::MID_Y_BASE + (bri_x <<< 7) - bri_x;
    end
    lower = gray < cfg_mid_q;
    diff  = $signed({2'b0, gray}) - $signed({2'b0, cfg_mid_q});

    s2_d.ctl.px    = in_q;
    s2_d.ctl.level = gray;
    if (!cfg_en_q) begin
      s2_d.ctl.mode = gmla_pkg::MODE_PASS;
    end else if (!adj) begin
      s2_d.ctl.mode = gmla_pkg::MODE_LEVEL;
    end else if (con_d == '0) begin
      s2_d.ctl.mode  = gmla_pkg::MODE_LEVEL;
      s2_d.ctl.level = lower ? 8'd0 : gmla_pkg::LEVEL_MAX;
    end else begin
      s2_d.ctl.mode = gmla_pkg::MODE_CURVE;
    end
    s2_d.diff_s = con_d[17] ? -diff : diff;
    s2_d.w      = lower ? cfg_mid_q : gmla_pkg::LEVEL_MAX - cfg_mid_q;
    s2_d.ad     = con_d[17] ? con_n[15:0] : con_d[15:0];
    s2_d.wzero  = !lower && (cfg_mid_q == gmla_pkg::LEVEL_MAX);
    s2_d.my     = my;
    s2_d.y      = lower ? my : gmla_pkg::FULL_Y - my;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q <= s2_d;
    end
  end

  // stage 2: |d|*w and Y*(gray-mid), negated when d is negative
  gmla_pkg::s3_t s3_d, s3_q;

  always_comb begin
    s3_d.ctl   = s2_q.ctl;
    s3_d.p1    = {8'b0, s2_q.ad} * {16'b0, s2_q.w};
    s3_d.yg    = s2_q.y * s2_q.diff_s;
    s3_d.my    = s2_q.my;
    s3_d.wzero = s2_q.wzero;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_q <= s3_d;
    end
  end

  // stage 3: midY*|d|*w, scaled terms, denominator
  gmla_pkg::s4_t s4_d, s4_q;

  always_comb begin
    s4_d.ctl = s3_q.ctl;
    if (s3_q.wzero) begin
      s4_d.t1  = {{25{s3_q.my[24]}}, s3_q.my};
      s4_d.qyg = '0;
      s4_d.dd  = 38'(gmla_pkg::Q_ONE);
    end else begin
      s4_d.t1  = s3_q.my * $signed({1'b0, s3_q.p1});
      s4_d.qyg = $signed({s3_q.yg, 14'b0});
      s4_d.dd  = {s3_q.p1, 14'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_q <= s4_d;
    end
  end

  // stage 4: numerator sum, rounding offset
  gmla_pkg::s5_t      s5_d, s5_q;
  logic signed [50:0] num;

  always_comb begin
    num       = s4_q.t1 + s4_q.qyg;
    s5_d.ctl  = s4_q.ctl;
    s5_d.neg  = num[50];
    s5_d.x    = {num[48:0], 1'b0} + {12'b0, s4_q.dd};
    s5_d.d2   = {s4_q.dd, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_q <= s5_d;
    end
  end

  // stage 5: overflow check, then one quotient bit per stage
  gmla_pkg::div_t div_d [QB+1];
  gmla_pkg::div_t div_q [QB+1];

  always_comb begin
    div_d[0].ctl  = s5_q.ctl;
    div_d[0].neg  = s5_q.neg;
    div_d[0].over = s5_q.x >= {3'b0, s5_q.d2, 8'b0};
    div_d[0].rem  = s5_q.x;
    div_d[0].d2   = s5_q.d2;
    div_d[0].q    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[DV0]) begin
      div_q[0] <= div_d[0];
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [gmla_pkg::DIV_W-1:0] sh;

    always_comb begin
      sh       = {11'b0, div_q[k-1].d2} << (QB - k);
      div_d[k] = div_q[k-1];
      if (div_q[k-1].rem >= sh) begin
        div_d[k].rem       = div_q[k-1].rem - sh;
        div_d[k].q[QB - k] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[DV0 + k]) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // output stage
  gmla_pkg::ctl_t out_ctl;
  logic [7:0]     lvl;
  gmla_pkg::pix_t out_d, out_q;

  always_comb begin
    out_ctl = div_q[QB].ctl;
    if (out_ctl.mode == gmla_pkg::MODE_CURVE) begin
      if (div_q[QB].neg) begin
        lvl = 8'd0;
      end else if (div_q[QB].over) begin
        lvl = gmla_pkg::LEVEL_MAX;
      end else begin
        lvl = div_q[QB].q;
      end
    end else begin
      lvl = out_ctl.level;
    end
    if (out_ctl.mode == gmla_pkg::MODE_PASS) begin
      out_d = out_ctl.px;
    end else begin
      out_d = '{r: lvl, g: lvl, b: lvl, a: out_ctl.px.a};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign red_out_o   = out_q.r;
  assign green_out_o = out_q.g;
  assign blue_out_o  = out_q.b;
  assign alpha_out_o = out_q.a;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output not blocked");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && s4_q.ctl.mode == gmla_pkg::MODE_CURVE |-> s4_q.dd != '0)
    else $error("zero denominator in curve path");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-2] && div_q[QB].ctl.mode == gmla_pkg::MODE_CURVE && !div_q[QB].over
      |-> div_q[QB].rem < {11'b0, div_q[QB].d2})
    else $error("divider remainder out of range");

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-2] && en[NS-1] && div_q[QB].ctl.mode != gmla_pkg::MODE_PASS
      |=> red_out_o == green_out_o && green_out_o == blue_out_o)
    else $error("gray output channels differ");
`endif

endmodule

`default_nettype wire
